// File: hdl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

  // Value range and window storage
  localparam int VALUE_COUNT = 256;
  localparam int VAL_W       = $clog2(VALUE_COUNT);
  localparam int NODE_W      = VAL_W + 1;
  localparam int TREE_DEPTH  = 2 * VALUE_COUNT;
  localparam int LEAF_W      = 7;
  localparam int SUM_W       = VAL_W + LEAF_W;
  localparam int MAX_WINDOW  = 64;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int FILL_W      = PTR_W + 1;

  localparam logic [LEAF_W-1:0] LEAF_MAX    = '1;
  localparam logic [PTR_W-1:0]  WIN_RESET   = PTR_W'(8);
  localparam logic [NODE_W-1:0] ROOT_NODE   = NODE_W'(1);

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic walk_start;
    logic walk_step;
    logic walk_add;
    logic walk_src_ring;
    logic search_start;
    logic search_step;
    logic ring_read;
    logic clear_en;
    logic load_out;
  } swm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic walk_done;
    logic search_done;
    logic warm;
    logic out_free;
  } swm_status_t;

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b00_0000_0001,
    ST_IDLE  = 10'b00_0000_0010,
    ST_ADD0  = 10'b00_0000_0100,
    ST_ADD   = 10'b00_0000_1000,
    ST_SRCH0 = 10'b00_0001_0000,
    ST_SRCH  = 10'b00_0010_0000,
    ST_RING  = 10'b00_0100_0000,
    ST_REM0  = 10'b00_1000_0000,
    ST_REM   = 10'b01_0000_0000,
    ST_EMIT  = 10'b10_0000_0000
  } swm_state_t;

endpackage

// File: hdl/swm_ctrl.sv
`timescale 1ns / 1ps

module swm_ctrl import swm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  swm_status_t status,
  output swm_cmd_t    cmd
);

  swm_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_ADD0;
        end
      end
      ST_ADD0: begin
        cmd.walk_start = 1'b1;
        cmd.walk_add   = 1'b1;
        state_next     = ST_ADD;
      end
      ST_ADD: begin
        cmd.walk_step = 1'b1;
        cmd.walk_add  = 1'b1;
        if (status.walk_done) state_next = status.warm ? ST_IDLE : ST_SRCH0;
      end
      ST_SRCH0: begin
        cmd.search_start = 1'b1;
        state_next       = ST_SRCH;
      end
      ST_SRCH: begin
        cmd.search_step = 1'b1;
        if (status.search_done) state_next = ST_RING;
      end
      ST_RING: begin
        cmd.ring_read = 1'b1;
        state_next    = ST_REM0;
      end
      ST_REM0: begin
        cmd.walk_start    = 1'b1;
        cmd.walk_src_ring = 1'b1;
        state_next        = ST_REM;
      end
      ST_REM: begin
        cmd.walk_step     = 1'b1;
        cmd.walk_src_ring = 1'b1;
        if (status.walk_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// File: hdl/swm_datapath.sv
`timescale 1ns / 1ps

module swm_datapath import swm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  swm_cmd_t          cmd,
  output swm_status_t       status,
  input  logic [VAL_W-1:0]  sample,
  input  logic              cfg_wr_en,
  input  logic [PTR_W-1:0]  cfg_wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAL_W-1:0]  median
);

  // Counting tree, heap order: root at 1, leaf of value v at VALUE_COUNT+v
  logic [SUM_W-1:0]  tree [TREE_DEPTH];
  logic [VAL_W-1:0]  ring [MAX_WINDOW];

  logic [PTR_W-1:0]  window_length;
  logic [PTR_W-1:0]  ring_pointer;
  logic [FILL_W-1:0] fill_count;
  logic [NODE_W-1:0] clr_addr;

  logic [VAL_W-1:0]  sample_q;
  logic [VAL_W-1:0]  ring_q;
  logic [PTR_W-1:0]  old_index;
  logic [PTR_W-1:0]  win_q;
  logic              warm;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] search_node;
  logic [PTR_W-1:0]  rank;
  logic [SUM_W-1:0]  rd_data;
  logic [VAL_W-1:0]  median_q;

  logic [NODE_W-1:0] rd_addr;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [SUM_W-1:0]  wr_data;
  logic [VAL_W-1:0]  walk_value;
  logic              at_leaf;
  logic              saturated;
  logic [NODE_W-1:0] node_next;
  logic              go_right;
  logic [NODE_W-1:0] search_next;
  logic [LEAF_W-1:0] leaf_count;

  assign walk_value  = cmd.walk_src_ring ? ring_q : sample_q;
  assign at_leaf     = node[VAL_W];
  assign leaf_count  = rd_data[LEAF_W-1:0];
  assign saturated   = at_leaf && (cmd.walk_add ? (leaf_count == LEAF_MAX)
                                                : (leaf_count == '0));
  assign node_next   = node >> 1;
  assign go_right    = {{(SUM_W-PTR_W){1'b0}}, rank} > rd_data;
  assign search_next = {search_node[NODE_W-2:0], go_right};

  // Tree port control
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = cmd.walk_add ? rd_data + SUM_W'(1) : rd_data - SUM_W'(1);
    if (cmd.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.walk_start) begin
      rd_addr = {1'b1, walk_value};
    end else if (cmd.walk_step) begin
      wr_en   = !saturated;
      rd_addr = node_next;
    end else if (cmd.search_start) begin
      rd_addr = {search_node[NODE_W-1:0] & '0} | NODE_W'(2);
    end else if (cmd.search_step) begin
      rd_addr = {search_next[NODE_W-2:0], 1'b0};
    end
  end

  // Tree memory
  always_ff @(posedge clk) begin
    if (wr_en) tree[wr_addr] <= wr_data;
    rd_data <= tree[rd_addr];
  end

  // Sample ring
  always_ff @(posedge clk) begin
    if (cmd.accept) ring[ring_pointer] <= sample;
    if (cmd.ring_read) ring_q <= ring[old_index];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WIN_RESET;
      ring_pointer  <= '0;
      fill_count    <= '0;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) window_length <= cfg_wr_data;
      if (cmd.clear_en) clr_addr <= clr_addr + NODE_W'(1);
      if (cmd.accept) begin
        ring_pointer <= ring_pointer + PTR_W'(1);
        if (fill_count < {1'b0, window_length}) fill_count <= fill_count + FILL_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q  <= sample;
      win_q     <= window_length;
      old_index <= ring_pointer - window_length;
      warm      <= fill_count < {1'b0, window_length};
    end
    if (cmd.walk_start) node <= {1'b1, walk_value};
    else if (cmd.walk_step) node <= node_next;
    if (cmd.search_start) begin
      search_node <= ROOT_NODE;
      rank        <= (win_q >> 1) + PTR_W'(1);
    end else if (cmd.search_step) begin
      search_node <= search_next;
      if (go_right) rank <= rank - rd_data[PTR_W-1:0];
      if (search_next[VAL_W]) median_q <= search_next[VAL_W-1:0];
    end
    if (cmd.load_out) median <= median_q;
  end

  assign status.clear_done  = (clr_addr == NODE_W'(TREE_DEPTH - 1));
  assign status.walk_done   = saturated || (node == ROOT_NODE);
  assign status.search_done = search_next[VAL_W];
  assign status.warm        = warm;
  assign status.out_free    = !out_valid || out_ready;

endmodule

// File: hdl/sliding_window_median.sv
`timescale 1ns / 1ps
// Running median over a stream of 8-bit unsigned samples.
// Input: s_axis_* carries one sample per transfer. Output: m_axis_* carries
// one median per transfer. Config: cfg_wr_en/cfg_wr_data set window_length
// (reset 8); write it only while the block is idle.
// The first window_length samples are counted only and give no output.
// After that, each sample gives the (window_length/2+1)-th smallest of the
// last window_length+1 samples, and the oldest of them is then uncounted.
// Counts live in a 512-entry counting tree (one read and one write port).
// Per sample: accept, leaf-to-root count update, rank descent, ring read,
// removal walk, output load; a warm-up sample ends after the count update.
// s_axis_tready is high only between samples. A removal that hits a zero
// count, or an add at 127, stops after the leaf read.
// After rst the tree is cleared, one entry per cycle, with s_axis_tready
// low. Results sit in an output register; while the receiver stalls the
// next sample is still accepted and processed, and the block waits only
// when it has a new result and the register is still full.
module sliding_window_median import swm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] sample
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] median
  input  logic             cfg_wr_en,
  input  logic [5:0]       cfg_wr_data     // window_length
);

  swm_cmd_t    cmd;
  swm_status_t status;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .median      (m_axis_tdata)
  );

endmodule
